// ----- src/kvc_pkg.sv -----
package kvc_pkg;

  // fixed field widths
  localparam int PORT_W  = 8;
  localparam int STAMP_W = 63;
  localparam int TMO_W   = 48;
  localparam int CMD_W   = 2;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 4;

  // parameter defaults
  localparam int CAPACITY_DEF   = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // register reset values
  localparam logic [PORT_W-1:0] SERVER_PORT_RST = '0;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST     = 48'd1000000000;

  // register index, taken from paddr bit 3
  localparam logic REG_SERVER_PORT = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET = 2'd0,
    CMD_PUT = 2'd1,
    CMD_DEL = 2'd2
  } kvc_cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_ACT   = 4'b1000
  } kvc_state_e;

  // classification made by the front
  typedef struct packed {
    logic               is_srv;
    logic               do_exp;
    logic [STAMP_W-1:0] bound;
  } kvc_cls_t;

endpackage

// ----- src/kvc_front.sv -----
module kvc_front import kvc_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PORT_W-1:0]     srv_port_i,
  input  logic [TMO_W-1:0]      timeout_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PORT_W-1:0]     in_port_i,
  input  logic [STAMP_W-1:0]    now_i,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [PORT_W-1:0]     client_port_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output logic [PORT_W-1:0]     q_port_o,
  output logic [STAMP_W-1:0]    q_now_o,
  output logic [CMD_W-1:0]      q_cmd_o,
  output logic [KEY_BITS-1:0]   q_key_o,
  output logic [VALUE_BITS-1:0] q_value_o,
  output logic [PORT_W-1:0]     q_cp_o,
  output kvc_cls_t              q_cls_o
);

  logic [PORT_W-1:0]     port_q  [2];
  logic [STAMP_W-1:0]    now_q   [2];
  logic [CMD_W-1:0]      cmd_q   [2];
  logic [KEY_BITS-1:0]   key_q   [2];
  logic [VALUE_BITS-1:0] value_q [2];
  logic [PORT_W-1:0]     cp_q    [2];
  kvc_cls_t              cls_q   [2];
  logic                  wp_q, wp_d, rp_q, rp_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  push;
  kvc_cls_t              cls;

  // classify the incoming word
  always_comb begin
    cls.is_srv = (in_port_i == srv_port_i);
    cls.do_exp = (now_i >= STAMP_W'(timeout_i));
    cls.bound  = now_i - STAMP_W'(timeout_i);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);

  // pointers and fill count
  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ q_pop_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      port_q[wp_q]  <= in_port_i;
      now_q[wp_q]   <= now_i;
      cmd_q[wp_q]   <= cmd_i;
      key_q[wp_q]   <= key_i;
      value_q[wp_q] <= value_i;
      cp_q[wp_q]    <= client_port_i;
      cls_q[wp_q]   <= cls;
    end
  end

  assign q_port_o  = port_q[rp_q];
  assign q_now_o   = now_q[rp_q];
  assign q_cmd_o   = cmd_q[rp_q];
  assign q_key_o   = key_q[rp_q];
  assign q_value_o = value_q[rp_q];
  assign q_cp_o    = cp_q[rp_q];
  assign q_cls_o   = cls_q[rp_q];

endmodule

// ----- src/kvc_back.sv -----
module kvc_back import kvc_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PORT_W-1:0]     srv_port_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  logic [PORT_W-1:0]     q_port_i,
  input  logic [STAMP_W-1:0]    q_now_i,
  input  logic [CMD_W-1:0]      q_cmd_i,
  input  logic [KEY_BITS-1:0]   q_key_i,
  input  logic [VALUE_BITS-1:0] q_value_i,
  input  logic [PORT_W-1:0]     q_cp_i,
  input  kvc_cls_t              q_cls_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_W-1:0]     out_port_o,
  output logic                  reply_o,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic [PORT_W-1:0]     client_port_out_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = 1 + KEY_BITS + VALUE_BITS + STAMP_W;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  kvc_state_e state_q, state_d;

  // table memory: valid, key, value, stamp
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rdata_q, wdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;

  logic [AW:0]   iss_q, iss_d;
  logic          chk_v_q, chk_v_d;
  logic [AW-1:0] chk_addr_q;

  logic                  found_q, found_d, free_q, free_d;
  logic [AW-1:0]         hslot_q, hslot_d, fslot_q, fslot_d;
  logic [VALUE_BITS-1:0] hval_q;

  // latched item
  logic [PORT_W-1:0]     it_port_q, it_cp_q;
  logic [STAMP_W-1:0]    it_now_q;
  logic [CMD_W-1:0]      it_cmd_q;
  logic [KEY_BITS-1:0]   it_key_q;
  logic [VALUE_BITS-1:0] it_val_q;
  kvc_cls_t              it_cls_q;

  // output register
  logic                  ov_q, ov_d;
  logic [PORT_W-1:0]     op_q, ocp_q, op_d, ocp_d;
  logic                  orep_q, ohit_q, orep_d, ohit_d;
  logic [VALUE_BITS-1:0] oval_q, oval_d;

  logic                  r_valid, r_exp, r_eff, r_match;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_val;
  logic [STAMP_W-1:0]    r_stamp;
  logic                  act_go, last_chk;

  // entry fields of the word read last cycle
  assign r_valid = rdata_q[EW-1];
  assign r_key   = rdata_q[EW-2 -: KEY_BITS];
  assign r_val   = rdata_q[VALUE_BITS+STAMP_W-1 -: VALUE_BITS];
  assign r_stamp = rdata_q[STAMP_W-1:0];
  assign r_exp   = r_valid && it_cls_q.do_exp && (r_stamp < it_cls_q.bound);
  assign r_eff   = r_valid && !r_exp;
  assign r_match = r_eff && (r_key == it_key_q);

  assign last_chk = chk_v_q && (chk_addr_q == LAST);
  assign act_go   = (state_q == ST_ACT) && (!ov_q || !out_stall_i);
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    chk_v_d = 1'b0;
    found_d = found_q;
    free_d  = free_q;
    hslot_d = hslot_q;
    fslot_d = fslot_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    waddr   = chk_addr_q;
    raddr   = iss_q[AW-1:0];
    wdata   = {1'b0, rdata_q[EW-2:0]};
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = iss_q[AW-1:0];
        wdata  = '0;
        iss_d  = iss_q + 1'b1;
        if (iss_q[AW-1:0] == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        iss_d   = '0;
        found_d = 1'b0;
        free_d  = 1'b0;
        if (q_valid_i) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        mem_re  = (iss_q < (AW+1)'(CAPACITY));
        chk_v_d = mem_re;
        iss_d   = mem_re ? iss_q + 1'b1 : iss_q;
        if (chk_v_q) begin
          mem_we = r_exp;
          if (r_match && !found_q) begin
            found_d = 1'b1;
            hslot_d = chk_addr_q;
          end
          if (!r_eff && !free_q) begin
            free_d  = 1'b1;
            fslot_d = chk_addr_q;
          end
        end
        if (last_chk) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        if (act_go) begin
          state_d = ST_IDLE;
          if (!it_cls_q.is_srv) begin
            if (found_q) begin
              mem_we = 1'b1;
              waddr  = hslot_q;
              wdata  = {(it_cmd_q != CMD_DEL), it_key_q,
                        (it_cmd_q == CMD_PUT) ? it_val_q : hval_q, it_now_q};
            end else if (it_cmd_q == CMD_PUT && free_q) begin
              mem_we = 1'b1;
              waddr  = fslot_q;
              wdata  = {1'b1, it_key_q, it_val_q, it_now_q};
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result of the item
  always_comb begin
    ov_d   = ov_q && out_stall_i;
    op_d   = op_q;
    orep_d = orep_q;
    ohit_d = ohit_q;
    oval_d = oval_q;
    ocp_d  = ocp_q;
    if (act_go) begin
      ov_d   = 1'b1;
      op_d   = it_cp_q;
      orep_d = 1'b0;
      ohit_d = 1'b0;
      oval_d = it_val_q;
      ocp_d  = it_cp_q;
      if (!it_cls_q.is_srv) begin
        if (found_q) begin
          op_d   = it_port_q;
          orep_d = 1'b1;
          ohit_d = 1'b1;
          if (it_cmd_q == CMD_GET) begin
            oval_d = hval_q;
          end
        end else if (it_cmd_q == CMD_PUT && free_q) begin
          op_d   = it_port_q;
          orep_d = 1'b1;
        end else begin
          op_d  = srv_port_i;
          ocp_d = it_port_q;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      iss_q   <= '0;
      chk_v_q <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      chk_v_q <= chk_v_d;
      found_q <= found_d;
      free_q  <= free_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_addr_q <= iss_q[AW-1:0];
    hslot_q    <= hslot_d;
    fslot_q    <= fslot_d;
    if (state_q == ST_SWEEP && chk_v_q && r_match && !found_q) begin
      hval_q <= r_val;
    end
    if (q_pop_o) begin
      it_port_q <= q_port_i;
      it_now_q  <= q_now_i;
      it_cmd_q  <= q_cmd_i;
      it_key_q  <= q_key_i;
      it_val_q  <= q_value_i;
      it_cp_q   <= q_cp_i;
      it_cls_q  <= q_cls_i;
    end
    op_q   <= op_d;
    orep_q <= orep_d;
    ohit_q <= ohit_d;
    oval_q <= oval_d;
    ocp_q  <= ocp_d;
  end

  // table memory port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o       = ov_q;
  assign out_port_o        = op_q;
  assign reply_o           = orep_q;
  assign hit_o             = ohit_q;
  assign value_out_o       = oval_q;
  assign client_port_out_o = ocp_q;

endmodule

// ----- src/kv_cache_with_expiry_core.sv -----
// Key-value cache with entry expiry, one request word in, one result word out.
// Input channel: in_valid_i / in_stall_o with the parsed request fields.
// Output channel: out_valid_o / out_stall_i with the forwarding decision.
// Registers over APB (64-bit data): server port at 0x0, entry timeout at 0x8.
// A two-word queue takes requests while the back end works on an earlier one.
// In the back end each request has a start step, a sweep of the table (one entry per
// cycle through the single read port, expiring, matching and finding the lowest free
// slot) and a final step that writes the entry, if any, and loads the result register.
// After reset the back end clears the table valid bits, one entry per cycle;
// requests queue up (two at most) during that pass.
// When the receiver stalls, the result is held and the back end waits in its
// final step; the queue still takes new requests until it is full.
module kv_cache_with_expiry_core import kvc_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PORT_W-1:0]     in_port_i,
  input  logic [STAMP_W-1:0]    now_i,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [PORT_W-1:0]     client_port_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_W-1:0]     out_port_o,
  output logic                  reply_o,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] value_out_o,
  output logic [PORT_W-1:0]     client_port_out_o
);

  logic [PORT_W-1:0]     srv_q;
  logic [TMO_W-1:0]      tmo_q;
  logic                  q_valid, q_pop;
  logic [PORT_W-1:0]     q_port, q_cp;
  logic [STAMP_W-1:0]    q_now;
  logic [CMD_W-1:0]      q_cmd;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_value;
  kvc_cls_t              q_cls;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_q <= SERVER_PORT_RST;
      tmo_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        REG_SERVER_PORT: srv_q <= pwdata[PORT_W-1:0];
        REG_TIMEOUT:     tmo_q <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3])
      REG_SERVER_PORT: prdata = DATA_W'(srv_q);
      REG_TIMEOUT:     prdata = DATA_W'(tmo_q);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  kvc_front #(
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .srv_port_i   (srv_q),
    .timeout_i    (tmo_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_port_i    (in_port_i),
    .now_i        (now_i),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .client_port_i(client_port_i),
    .q_valid_o    (q_valid),
    .q_pop_i      (q_pop),
    .q_port_o     (q_port),
    .q_now_o      (q_now),
    .q_cmd_o      (q_cmd),
    .q_key_o      (q_key),
    .q_value_o    (q_value),
    .q_cp_o       (q_cp),
    .q_cls_o      (q_cls)
  );

  kvc_back #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .srv_port_i       (srv_q),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_port_i         (q_port),
    .q_now_i          (q_now),
    .q_cmd_i          (q_cmd),
    .q_key_i          (q_key),
    .q_value_i        (q_value),
    .q_cp_i           (q_cp),
    .q_cls_i          (q_cls),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_port_o       (out_port_o),
    .reply_o          (reply_o),
    .hit_o            (hit_o),
    .value_out_o      (value_out_o),
    .client_port_out_o(client_port_out_o)
  );

endmodule

// ----- src/kvc_chk.sv -----
module kvc_chk import kvc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  reply_o,
  input logic                  hit_o,
  input logic [VALUE_BITS-1:0] value_out_o
);

  // a hit is always answered by the cache
  a_hit_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> reply_o)
    else $error("hit without reply");

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output word valid in reset");

  // stalled word stays
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_hold_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_out_o) && $stable(hit_o))
    else $error("output word changed under stall");

endmodule

bind kv_cache_with_expiry_core kvc_chk #(
  .VALUE_BITS(VALUE_BITS)
) u_kvc_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .reply_o    (reply_o),
  .hit_o      (hit_o),
  .value_out_o(value_out_o)
);

// ----- sim/kv_cache_with_expiry_core_test.sv -----
module kv_cache_with_expiry_core_test;
  import kvc_pkg::*;

  localparam int TABLE_SIZE = CAPACITY_DEF;
  // two-bit command code with no operation of its own, only a stamp refresh on a hit
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_SERVER_PORT = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT     = 4'h8;
  localparam logic [TMO_W-1:0]  TIMEOUT_MAX      = '1;

  typedef struct {
    logic [PORT_W-1:0]         port;
    logic [STAMP_W-1:0]        now;
    logic [CMD_W-1:0]          cmd;
    logic [KEY_BITS_DEF-1:0]   key;
    logic [VALUE_BITS_DEF-1:0] value;
    logic [PORT_W-1:0]         client;
  } request_t;

  typedef struct {
    logic [PORT_W-1:0]         out_port;
    logic                      reply;
    logic                      hit;
    logic [VALUE_BITS_DEF-1:0] value;
    logic [PORT_W-1:0]         client;
  } verdict_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [PORT_W-1:0]         in_port_i;
  logic [STAMP_W-1:0]        now_i;
  logic [CMD_W-1:0]          cmd_i;
  logic [KEY_BITS_DEF-1:0]   key_i;
  logic [VALUE_BITS_DEF-1:0] value_i;
  logic [PORT_W-1:0]         client_port_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [PORT_W-1:0]         out_port_o;
  logic                      reply_o;
  logic                      hit_o;
  logic [VALUE_BITS_DEF-1:0] value_out_o;
  logic [PORT_W-1:0]         client_port_out_o;

  kv_cache_with_expiry_core DUT (.*);

  // shadow table and register copies
  logic                      tbl_valid [TABLE_SIZE];
  logic [KEY_BITS_DEF-1:0]   tbl_key   [TABLE_SIZE];
  logic [VALUE_BITS_DEF-1:0] tbl_value [TABLE_SIZE];
  logic [STAMP_W-1:0]        tbl_stamp [TABLE_SIZE];
  logic [PORT_W-1:0]         srv_port;
  logic [TMO_W-1:0]          timeout;

  request_t pending_reqs[$];
  verdict_t expected_verdicts[$];
  logic [STAMP_W-1:0] clock_ns;
  logic taken;
  logic calm;
  int errors, words_in, words_out, hits_seen, replies_seen, server_bound;

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // expire, then look up and update the shadow table for one request
  function automatic verdict_t serve(request_t r);
    verdict_t v;
    logic [STAMP_W-1:0] bound;
    int slot;
    slot = -1;
    v.out_port = r.client;
    v.reply = 1'b0;
    v.hit = 1'b0;
    v.value = r.value;
    v.client = r.client;
    if (r.now >= STAMP_W'(timeout)) begin
      bound = r.now - STAMP_W'(timeout);
      for (int i = 0; i < TABLE_SIZE; i++)
        if (tbl_valid[i] && tbl_stamp[i] < bound) tbl_valid[i] = 1'b0;
    end
    if (r.port == srv_port) return v;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (tbl_valid[i] && tbl_key[i] == r.key) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      tbl_stamp[slot] = r.now;
      if (r.cmd == CMD_GET) v.value = tbl_value[slot];
      else if (r.cmd == CMD_PUT) tbl_value[slot] = r.value;
      else if (r.cmd == CMD_DEL) tbl_valid[slot] = 1'b0;
      v.out_port = r.port;
      v.reply = 1'b1;
      v.hit = 1'b1;
      return v;
    end
    if (r.cmd == CMD_PUT) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (!tbl_valid[i]) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0) begin
        tbl_valid[slot] = 1'b1;
        tbl_key[slot] = r.key;
        tbl_value[slot] = r.value;
        tbl_stamp[slot] = r.now;
        v.out_port = r.port;
        v.reply = 1'b1;
        return v;
      end
    end
    v.out_port = srv_port;
    v.client = r.port;
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on %s at result %0d: got %h, want %h", what, words_out, got, want);
  endtask

  // driver: request word and result stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || taken) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          in_port_i     <= pending_reqs[0].port;
          now_i         <= pending_reqs[0].now;
          cmd_i         <= pending_reqs[0].cmd;
          key_i         <= pending_reqs[0].key;
          value_i       <= pending_reqs[0].value;
          client_port_i <= pending_reqs[0].client;
          in_valid_i    <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 12);
    end
  end

  // monitor: predict on acceptance, compare on delivery
  always @(posedge clk_i) begin
    verdict_t w;
    request_t r;
    taken = 1'b0;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        r.port = in_port_i;
        r.now = now_i;
        r.cmd = cmd_i;
        r.key = key_i;
        r.value = value_i;
        r.client = client_port_i;
        expected_verdicts.push_back(serve(r));
        words_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("unexpected result word %0d", words_out);
        end else begin
          w = expected_verdicts.pop_front();
          if (out_port_o !== w.out_port) report("out_port", out_port_o, w.out_port);
          if (reply_o !== w.reply) report("reply", reply_o, w.reply);
          if (hit_o !== w.hit) report("hit", hit_o, w.hit);
          if (value_out_o !== w.value) report("value_out", value_out_o, w.value);
          if (client_port_out_o !== w.client)
            report("client_port_out", client_port_out_o, w.client);
          hits_seen += w.hit;
          replies_seen += w.reply;
          if (!w.reply && w.out_port == srv_port) server_bound++;
        end
      end
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_SERVER_PORT) srv_port = data[PORT_W-1:0];
    else timeout = data[TMO_W-1:0];
  endtask

  task automatic push_req(logic [PORT_W-1:0] port, logic [CMD_W-1:0] cmd,
                          logic [KEY_BITS_DEF-1:0] key, logic [VALUE_BITS_DEF-1:0] value,
                          logic [PORT_W-1:0] client, logic [STAMP_W-1:0] step_ns);
    request_t r;
    clock_ns = clock_ns + step_ns;
    r.port = port;
    r.now = clock_ns;
    r.cmd = cmd;
    r.key = key;
    r.value = value;
    r.client = client;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(int count);
    logic [PORT_W-1:0] port;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < count; n++) begin
      port = ($urandom_range(0, 99) < 10) ? srv_port : PORT_W'($urandom);
      cmd = ($urandom_range(0, 99) < 6) ? CMD_TOUCH : CMD_W'($urandom_range(0, 2));
      push_req(port, cmd,
               ($urandom_range(0, 99) < 85) ? KEY_BITS_DEF'($urandom_range(0, 15)) : $urandom,
               {$urandom, $urandom}, PORT_W'($urandom), STAMP_W'($urandom_range(0, 25)));
    end
  endtask

  // sender holds off until the block is empty and the sweep has drained
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_verdicts.size() > 0)
      @(negedge clk_i);
    repeat (TABLE_SIZE + 10) @(negedge clk_i);
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    in_port_i = '0;
    now_i = '0;
    cmd_i = '0;
    key_i = '0;
    value_i = '0;
    client_port_i = '0;
    calm = 1'b0;
    taken = 1'b0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    hits_seen = 0;
    replies_seen = 0;
    server_bound = 0;
    clock_ns = '0;
    srv_port = SERVER_PORT_RST;
    timeout = TIMEOUT_RST;
    for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: server packet, each command on hit and miss, field extremes
    push_req(8'h00, CMD_GET, 32'h5, 64'h1234, 8'hff, 63'd10);
    push_req(8'h03, CMD_GET, 32'h5, 64'h0, 8'h00, 63'd1);
    push_req(8'h03, CMD_PUT, 32'h5, '1, 8'h44, 63'd1);
    push_req(8'h04, CMD_GET, 32'h5, 64'h0, 8'h11, 63'd1);
    push_req(8'hff, CMD_PUT, 32'h5, 64'h8000_0000_0000_0001, 8'hff, 63'd1);
    push_req(8'h04, CMD_TOUCH, 32'h5, 64'hdead_beef, 8'h01, 63'd1);
    push_req(8'h04, CMD_TOUCH, 32'h9, 64'h77, 8'h02, 63'd1);
    push_req(8'h05, CMD_DEL, 32'h5, 64'h0, 8'h03, 63'd1);
    push_req(8'h05, CMD_GET, 32'h5, 64'h0, 8'h03, 63'd1);
    push_req(8'h05, CMD_DEL, 32'h5, 64'h0, 8'h03, 63'd1);
    push_req(8'h01, CMD_PUT, 32'h0, 64'h0, 8'h80, 63'd1);
    push_req(8'h01, CMD_PUT, '1, 64'h5555_aaaa_5555_aaaa, 8'h7f, 63'd1);
    push_req(8'h02, CMD_GET, '1, 64'h0, 8'h00, 63'd1);
    push_req(8'h02, CMD_GET, 32'h0, 64'h0, 8'h00, 63'd1);
    // expiry boundary: kept at exactly the bound, gone one past it
    push_req(8'h06, CMD_PUT, 32'h7, 64'h99, 8'h06, 63'd5);
    push_req(8'h06, CMD_GET, 32'h7, 64'h0, 8'h06, 63'd1000000000);
    push_req(8'h06, CMD_GET, 32'h7, 64'h0, 8'h06, 63'd1000000001);
    drain();

    // zero timeout: everything older than now is dropped
    reg_write(ADDR_SERVER_PORT, 64'hff);
    reg_write(ADDR_TIMEOUT, 64'h0);
    push_random(40);
    drain();

    // longest timeout: fill the table, then miss on a full table
    reg_write(ADDR_SERVER_PORT, 64'h11);
    reg_write(ADDR_TIMEOUT, {16'h0, TIMEOUT_MAX});
    calm = 1'b1;
    for (int i = 0; i < TABLE_SIZE + 8; i++)
      push_req(8'h20, CMD_PUT, 32'h1000_0000 + i, {$urandom, $urandom}, 8'h21, 63'd1);
    for (int i = 0; i < 8; i++)
      push_req(8'h22, CMD_GET, 32'h1000_0000 + $urandom_range(0, TABLE_SIZE + 7), 64'h0,
               8'h23, 63'd1);
    drain();
    calm = 1'b0;

    // short timeout, busy small key set, first stretch without idling
    reg_write(ADDR_SERVER_PORT, 64'hc8);
    reg_write(ADDR_TIMEOUT, 64'd40);
    calm = 1'b1;
    push_random(150);
    while (pending_reqs.size() > 0) @(negedge clk_i);
    calm = 1'b0;
    push_random(450);
    drain();

    // far future time, then the longest timeout again
    reg_write(ADDR_TIMEOUT, 64'd300);
    clock_ns = clock_ns + 63'h4000_0000_0000_0000;
    push_random(120);
    drain();
    reg_write(ADDR_SERVER_PORT, 64'h00);
    reg_write(ADDR_TIMEOUT, {16'h0, TIMEOUT_MAX});
    clock_ns = clock_ns + 63'h2000_0000_0000_0000;
    push_random(120);
    drain();

    if (expected_verdicts.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_verdicts.size());
    end
    $display("requests %0d, results %0d: %0d hits, %0d answered by the cache, %0d to server",
             words_in, words_out, hits_seen, replies_seen, server_bound);
    $display("covered full table, zero and longest timeout, expiry bound, far future time");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/kvc_pkg.sv
src/kvc_front.sv
src/kvc_back.sv
src/kv_cache_with_expiry_core.sv
src/kvc_chk.sv
sim/kv_cache_with_expiry_core_test.sv
